// ===== sv/event_denoise_row_col_filter_defines.svh =====
// Assertion macros shared by the event denoise filter RTL.
`ifndef EVENT_DENOISE_ROW_COL_FILTER_DEFINES_SVH
`define EVENT_DENOISE_ROW_COL_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define EDRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("event denoise filter assertion failed");
`define EDRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("event denoise filter assertion failed");
`else
`define EDRC_ASSERT(lbl, clk, rst_n, prop)
`define EDRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/edrc_pkg.sv =====
// Shared types and constants of the event denoise row/column filter.
package edrc_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int TS_W   = 64;
  localparam int POS_W  = 10;
  localparam int THR_W  = 3;
  localparam int WIN_W  = 31;
  localparam int SIZE_W = 11;
  localparam int SUP_W  = 3;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1);
  localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(1000);
  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = CFG_IDX_W'(0),
    REG_TIME_WINDOW = CFG_IDX_W'(1),
    REG_COLS        = CFG_IDX_W'(2),
    REG_ROWS        = CFG_IDX_W'(3)
  } reg_idx_t;

  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic             pol;
    logic [POS_W-1:0] addr;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic on_sensor;
    logic lo;
    logic hi;
  } nbr_guard_t;

endpackage

// ===== sv/edrc_ifs.sv =====
// Channel interfaces of the event denoise filter: events, results and configuration.
interface edrc_event_if;
  logic                          valid;
  logic                          ready;
  logic [edrc_pkg::TS_W-1:0]     timestamp;
  logic [edrc_pkg::POS_W-1:0]    col;
  logic [edrc_pkg::POS_W-1:0]    row;
  logic                          polarity;

  modport source (output valid, timestamp, col, row, polarity, input ready);
  modport sink (input valid, timestamp, col, row, polarity, output ready);
endinterface

interface edrc_result_if;
  logic valid;
  logic ready;
  logic keep;

  modport source (output valid, keep, input ready);
  modport sink (input valid, keep, output ready);
endinterface

interface edrc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [edrc_pkg::CFG_IDX_W-1:0]   index;
  logic [edrc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/edrc_ram.sv =====
// Generic simple dual-read RAM with one write port and registered reads.
module edrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_a,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/edrc_line_store.sv =====
// One axis of cell storage: two banked RAMs, neighbor reads, write forwarding and clearing.
module edrc_line_store #(
  parameter int MAX_POS = edrc_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(MAX_POS)-1:0]  rd_pos,
  input  edrc_pkg::nbr_guard_t        rd_guard,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_POS)-1:0]  wr_pos,
  input  edrc_pkg::cell_t             wr_cell,
  output edrc_pkg::cell_t             cell_prev,
  output edrc_pkg::cell_t             cell_own,
  output edrc_pkg::cell_t             cell_next,
  output logic                        ready
);

  localparam int PAW = $clog2(MAX_POS);
  localparam int HC  = (MAX_POS + 1) / 2;
  localparam int HAW = (HC > 1) ? $clog2(HC) : 1;

  logic [PAW-1:0] prev_pos;
  logic [PAW-1:0] next_pos;
  logic [HAW-1:0] own_idx;
  logic [HAW-1:0] prev_idx;
  logic [HAW-1:0] next_idx;

  logic           clr_busy_r;
  logic [HAW-1:0] clr_idx_r;

  logic                  fwd_valid_r;
  logic [PAW-1:0]        fwd_pos_r;
  edrc_pkg::cell_t       fwd_cell_r;

  logic           own_bank_r;
  logic [PAW-1:0] p_prev_r;
  logic [PAW-1:0] p_own_r;
  logic [PAW-1:0] p_next_r;

  logic [edrc_pkg::CELL_W-1:0] rd_a [2];
  logic [edrc_pkg::CELL_W-1:0] rd_b [2];

  edrc_pkg::cell_t raw_prev;
  edrc_pkg::cell_t raw_own;
  edrc_pkg::cell_t raw_next;

  assign prev_pos = rd_pos - PAW'(1);
  assign next_pos = rd_pos + PAW'(1);
  assign own_idx  = rd_guard.on_sensor ? HAW'(rd_pos >> 1) : '0;
  assign prev_idx = (rd_guard.on_sensor && rd_guard.lo) ? HAW'(prev_pos >> 1) : '0;
  assign next_idx = (rd_guard.on_sensor && rd_guard.hi) ? HAW'(next_pos >> 1) : '0;

  for (genvar k = 0; k < 2; k++) begin : g_bank
    logic                        is_own;
    logic                        we;
    logic [HAW-1:0]              waddr;
    logic [edrc_pkg::CELL_W-1:0] wdata;

    assign is_own = (rd_pos[0] == 1'(k));
    assign we     = clr_busy_r || (wr_en && (wr_pos[0] == 1'(k)));
    assign waddr  = clr_busy_r ? clr_idx_r : HAW'(wr_pos >> 1);
    assign wdata  = clr_busy_r ? '0 : wr_cell;

    edrc_ram #(
      .WIDTH (edrc_pkg::CELL_W),
      .DEPTH (HC)
    ) u_ram (
      .clk     (clk),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .re      (rd_en),
      .raddr_a (is_own ? own_idx : prev_idx),
      .raddr_b (next_idx),
      .rdata_a (rd_a[k]),
      .rdata_b (rd_b[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_idx_r == HAW'(HC - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + HAW'(1);
        end
      end
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_pos_r  <= wr_pos;
      fwd_cell_r <= wr_cell;
    end
    if (rd_en) begin
      own_bank_r <= rd_pos[0];
      p_prev_r   <= prev_pos;
      p_own_r    <= rd_pos;
      p_next_r   <= next_pos;
    end
  end

  // The write issued in the same cycle as a read is not yet visible in the RAM.
  always_comb begin
    raw_own  = own_bank_r ? rd_a[1] : rd_a[0];
    raw_prev = own_bank_r ? rd_a[0] : rd_a[1];
    raw_next = own_bank_r ? rd_b[0] : rd_b[1];
    cell_own  = (fwd_valid_r && fwd_pos_r == p_own_r) ? fwd_cell_r : raw_own;
    cell_prev = (fwd_valid_r && fwd_pos_r == p_prev_r) ? fwd_cell_r : raw_prev;
    cell_next = (fwd_valid_r && fwd_pos_r == p_next_r) ? fwd_cell_r : raw_next;
  end

  assign ready = !clr_busy_r;

endmodule

// ===== sv/event_denoise_row_col_filter.sv =====
// Top level of the event denoise filter with one stored cell per column and per row.
// Events enter on in_ch (timestamp, col, row, polarity) and each one yields exactly
// one transaction on out_ch carrying keep. keep is 1 when enough of the six
// neighboring column and row cells hold a recent event of the same polarity on an
// adjacent pixel. Events outside the configured sensor give keep 0 and change nothing.
// Configuration is written over cfg_ch (index 0 threshold, 1 time window, 2 columns,
// 3 rows); cfg_ch is always ready. Writes must be made only while the block is idle;
// the block itself does not enforce this. Each event passes through the s1 stage
// registers and then the output register. One event is accepted per cycle while out_ch
// takes results and no clearing pass runs; column and row cells sit in even/odd banked
// RAMs so the three reads of each axis and the write-back go together, with the last
// write forwarded to the following event.
// After reset a clearing pass zeroes the RAMs; in_ch.ready stays low during that pass.
// When the receiver stalls, the result is held in the output register and in_ch.ready
// drops until that result is taken, so no transaction is lost or repeated.
`include "event_denoise_row_col_filter_defines.svh"

module event_denoise_row_col_filter #(
  parameter int MAX_COLS = edrc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = edrc_pkg::MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  edrc_event_if.sink          in_ch,
  edrc_result_if.source       out_ch,
  edrc_cfg_if.sink            cfg_ch
);

  localparam int CAW  = $clog2(MAX_COLS);
  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int EW_C = ($clog2(MAX_COLS + 1) > edrc_pkg::SIZE_W) ?
                        $clog2(MAX_COLS + 1) : edrc_pkg::SIZE_W;
  localparam int EW_R = ($clog2(MAX_ROWS + 1) > edrc_pkg::SIZE_W) ?
                        $clog2(MAX_ROWS + 1) : edrc_pkg::SIZE_W;

  logic [edrc_pkg::THR_W-1:0]  thr_r;
  logic [edrc_pkg::WIN_W-1:0]  win_r;
  logic [edrc_pkg::SIZE_W-1:0] cols_r;
  logic [edrc_pkg::SIZE_W-1:0] rows_r;

  logic [EW_C-1:0] w_eff;
  logic [EW_R-1:0] h_eff;
  logic [EW_C-1:0] x_ext;
  logic [EW_R-1:0] y_ext;

  logic adv;
  logic accept;
  logic stores_ready;
  logic col_ready;
  logic row_ready;

  edrc_pkg::nbr_guard_t col_guard;
  edrc_pkg::nbr_guard_t row_guard;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic                         s1_in_r;
  logic [edrc_pkg::TS_W-1:0]    s1_ts_r;
  logic [edrc_pkg::POS_W-1:0]   s1_x_r;
  logic [edrc_pkg::POS_W-1:0]   s1_y_r;
  logic                         s1_pol_r;
  logic                         s1_xl_r;
  logic                         s1_xh_r;
  logic                         s1_yl_r;
  logic                         s1_yh_r;

  logic out_valid_r;
  logic out_valid_nxt;
  logic out_keep_r;
  logic out_keep_nxt;

  edrc_pkg::cell_t col_prev;
  edrc_pkg::cell_t col_own;
  edrc_pkg::cell_t col_next;
  edrc_pkg::cell_t row_prev;
  edrc_pkg::cell_t row_own;
  edrc_pkg::cell_t row_next;

  logic                         wr_en;
  edrc_pkg::cell_t              col_wr_cell;
  edrc_pkg::cell_t              row_wr_cell;
  logic [edrc_pkg::SUP_W-1:0]   support;
  logic                         keep;

  function automatic logic cell_hit(
    edrc_pkg::cell_t              c,
    logic [edrc_pkg::TS_W-1:0]    ts,
    logic                         pol,
    logic [edrc_pkg::WIN_W-1:0]   win,
    logic [edrc_pkg::POS_W-1:0]   p,
    logic                         lo,
    logic                         hi,
    logic                         centre
  );
    logic [edrc_pkg::TS_W-1:0]  dt;
    logic [edrc_pkg::POS_W:0]   a;
    logic [edrc_pkg::POS_W:0]   pp;
    logic                       adj;
    dt  = ts - c.ts;
    a   = {1'b0, c.addr};
    pp  = {1'b0, p};
    adj = (lo && a == pp - (edrc_pkg::POS_W + 1)'(1)) || (centre && a == pp) ||
          (hi && a == pp + (edrc_pkg::POS_W + 1)'(1));
    return (dt <= edrc_pkg::TS_W'(win)) && (c.pol == pol) && adj;
  endfunction

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= edrc_pkg::THR_RESET;
      win_r  <= edrc_pkg::WIN_RESET;
      cols_r <= edrc_pkg::COLS_RESET;
      rows_r <= edrc_pkg::ROWS_RESET;
    end else if (cfg_ch.valid) begin
      case (edrc_pkg::reg_idx_t'(cfg_ch.index))
        edrc_pkg::REG_THRESHOLD:   thr_r  <= cfg_ch.data[edrc_pkg::THR_W-1:0];
        edrc_pkg::REG_TIME_WINDOW: win_r  <= cfg_ch.data[edrc_pkg::WIN_W-1:0];
        edrc_pkg::REG_COLS:        cols_r <= cfg_ch.data[edrc_pkg::SIZE_W-1:0];
        edrc_pkg::REG_ROWS:        rows_r <= cfg_ch.data[edrc_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cols_r == '0) begin
      w_eff = EW_C'(1);
    end else if (EW_C'(cols_r) > EW_C'(MAX_COLS)) begin
      w_eff = EW_C'(MAX_COLS);
    end else begin
      w_eff = EW_C'(cols_r);
    end
    if (rows_r == '0) begin
      h_eff = EW_R'(1);
    end else if (EW_R'(rows_r) > EW_R'(MAX_ROWS)) begin
      h_eff = EW_R'(MAX_ROWS);
    end else begin
      h_eff = EW_R'(rows_r);
    end
  end

  // Input stage: edge guards and RAM read requests.
  assign x_ext        = EW_C'(in_ch.col);
  assign y_ext        = EW_R'(in_ch.row);
  assign stores_ready = col_ready && row_ready;
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv && stores_ready;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    col_guard.on_sensor = (x_ext < w_eff) && (y_ext < h_eff);
    col_guard.lo        = (in_ch.col != '0);
    col_guard.hi        = (x_ext + EW_C'(1)) < w_eff;
    row_guard.on_sensor = col_guard.on_sensor;
    row_guard.lo        = (in_ch.row != '0);
    row_guard.hi        = (y_ext + EW_R'(1)) < h_eff;
  end

  assign wr_en       = adv && s1_valid_r && s1_in_r;
  assign col_wr_cell = '{ts: s1_ts_r, pol: s1_pol_r, addr: s1_y_r};
  assign row_wr_cell = '{ts: s1_ts_r, pol: s1_pol_r, addr: s1_x_r};

  edrc_line_store #(
    .MAX_POS (MAX_COLS)
  ) u_col_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_pos    (CAW'(in_ch.col)),
    .rd_guard  (col_guard),
    .wr_en     (wr_en),
    .wr_pos    (CAW'(s1_x_r)),
    .wr_cell   (col_wr_cell),
    .cell_prev (col_prev),
    .cell_own  (col_own),
    .cell_next (col_next),
    .ready     (col_ready)
  );

  edrc_line_store #(
    .MAX_POS (MAX_ROWS)
  ) u_row_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_pos    (RAW'(in_ch.row)),
    .rd_guard  (row_guard),
    .wr_en     (wr_en),
    .wr_pos    (RAW'(s1_y_r)),
    .wr_cell   (row_wr_cell),
    .cell_prev (row_prev),
    .cell_own  (row_own),
    .cell_next (row_next),
    .ready     (row_ready)
  );

  // Support count over the six neighbor cells.
  always_comb begin
    support =
      edrc_pkg::SUP_W'(s1_xl_r && cell_hit(col_prev, s1_ts_r, s1_pol_r, win_r, s1_y_r,
                                           s1_yl_r, s1_yh_r, 1'b1)) +
      edrc_pkg::SUP_W'(cell_hit(col_own, s1_ts_r, s1_pol_r, win_r, s1_y_r,
                                s1_yl_r, s1_yh_r, 1'b0)) +
      edrc_pkg::SUP_W'(s1_xh_r && cell_hit(col_next, s1_ts_r, s1_pol_r, win_r, s1_y_r,
                                           s1_yl_r, s1_yh_r, 1'b1)) +
      edrc_pkg::SUP_W'(s1_yl_r && cell_hit(row_prev, s1_ts_r, s1_pol_r, win_r, s1_x_r,
                                           s1_xl_r, s1_xh_r, 1'b1)) +
      edrc_pkg::SUP_W'(cell_hit(row_own, s1_ts_r, s1_pol_r, win_r, s1_x_r,
                                s1_xl_r, s1_xh_r, 1'b0)) +
      edrc_pkg::SUP_W'(s1_yh_r && cell_hit(row_next, s1_ts_r, s1_pol_r, win_r, s1_x_r,
                                           s1_xl_r, s1_xh_r, 1'b1));
    keep = s1_in_r && (support >= thr_r);
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_keep_nxt  = out_keep_r;
    if (adv) begin
      s1_valid_nxt  = accept;
      out_valid_nxt = s1_valid_r;
      out_keep_nxt  = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_keep_r <= out_keep_nxt;
    if (accept) begin
      s1_in_r  <= col_guard.on_sensor;
      s1_ts_r  <= in_ch.timestamp;
      s1_x_r   <= in_ch.col;
      s1_y_r   <= in_ch.row;
      s1_pol_r <= in_ch.polarity;
      s1_xl_r  <= col_guard.lo;
      s1_xh_r  <= col_guard.hi;
      s1_yl_r  <= row_guard.lo;
      s1_yh_r  <= row_guard.hi;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.keep  = out_keep_r;

  `EDRC_ASSERT(a_accept_enters_s1, clk, rst_n, accept |=> s1_valid_r)
  `EDRC_ASSERT(a_result_from_s1, clk, rst_n, $rose(out_valid_r) |-> $past(s1_valid_r))
  `EDRC_ASSERT(a_zero_thr_keeps, clk, rst_n, (wr_en && thr_r == '0) |=> out_keep_r)
  `EDRC_ASSERT(a_no_write_in_clear, clk, rst_n, wr_en |-> stores_ready)

endmodule
